>>> sv/external_id_remapper_macros.svh
// Assertion macros for the external identifier remapper.
// Used by the modules that carry assertions; expects clk_i and rst_ni in scope.
`ifndef EXTERNAL_ID_REMAPPER_MACROS_SVH
`define EXTERNAL_ID_REMAPPER_MACROS_SVH

// Condition in the same cycle as the trigger.
`define EIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Condition in the cycle after the trigger.
`define EIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> sv/eir_pkg.sv
// Package for the external identifier remapper: sizes, shared types.
// No dependencies; used by every other file of the block but the assertion macros header.
`timescale 1ns / 1ps

package eir_pkg;

  // Table size and key width.
  localparam int unsigned ENTRIES  = 1024;
  localparam int unsigned KEY_BITS = 32;

  // Fixed field widths of the channels.
  localparam int unsigned EXT_W = 32;
  localparam int unsigned ID_W  = 10;

  // Index into the store and count of used positions (0 to ENTRIES).
  localparam int unsigned INDEX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned COUNT_W = $clog2(ENTRIES + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Request from the sequencer to the key store.
  typedef struct packed {
    logic   wr_en;
    index_t wr_addr;
    key_t   wr_data;
    logic   rd_en;
    index_t rd_addr;
  } mem_req_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0] dense_idx;
    logic            is_new;
    logic            table_full;
  } res_t;

endpackage

>>> sv/eir_channels.sv
// Valid/ready channel interfaces for the remapper's input and result items.
// Depends on eir_pkg for the field widths.
`timescale 1ns / 1ps

// Input channel: one external identifier per item.
interface eir_in_if;
  logic                     valid;
  logic                     ready;
  logic [eir_pkg::EXT_W-1:0] ext_key;

  modport source (output valid, output ext_key, input ready);
  modport sink   (input valid, input ext_key, output ready);
endinterface

// Result channel: dense index and status flags per item.
interface eir_out_if;
  logic                    valid;
  logic                    ready;
  logic [eir_pkg::ID_W-1:0] dense_idx;
  logic                    is_new;
  logic                    table_full;

  modport source (output valid, output dense_idx, output is_new, output table_full,
                  input ready);
  modport sink   (input valid, input dense_idx, input is_new, input table_full,
                  output ready);
endinterface

>>> sv/external_id_remapper.sv
// Top level of the external identifier remapper: sequencer, key store, result register.
// Depends on eir_pkg, eir_channels, eir_key_store and eir_scan_seq.
//
//   Channel | Direction | Payload                              | Handshake
//   in_i    | input     | ext_key                              | valid / ready
//   out_o   | output    | dense_idx, is_new, table_full        | valid / ready
//
// During an item's scan, one read of the key store is issued and one stored key
// compared per cycle over the used positions, so the count of keys stored so far
// sets the length of the scan; a hit ends the scan early.
// Reset is asynchronous and active low; it empties the table at once, without a sweep.
// A finished result waits in an output register while the next item is taken;
// the scan holds at its end while that register is still occupied.
`timescale 1ns / 1ps

module external_id_remapper (
  input  logic      clk_i,
  input  logic      rst_ni,
  eir_in_if.sink    in_i,
  eir_out_if.source out_o
);

  eir_pkg::mem_req_t mem_req;
  eir_pkg::key_t     rd_data;
  eir_pkg::res_t     res;
  logic              res_valid;
  logic              res_ready;

  logic          out_valid_q;
  eir_pkg::res_t out_res_q;

  assign res_ready = !out_valid_q;

  eir_scan_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .ext_key_i   (in_i.ext_key),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  eir_key_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: filled by the sequencer, emptied by the sink.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.dense_idx  = out_res_q.dense_idx;
  assign out_o.is_new     = out_res_q.is_new;
  assign out_o.table_full = out_res_q.table_full;

endmodule

>>> sv/eir_key_store.sv
// Key store: one write port and one registered read port.
// Depends on eir_pkg for the request type and sizes.
`timescale 1ns / 1ps

module eir_key_store (
  input  logic              clk_i,
  input  eir_pkg::mem_req_t req_i,
  output eir_pkg::key_t     rd_data_o
);

  eir_pkg::key_t mem_q [eir_pkg::ENTRIES];
  eir_pkg::key_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/eir_scan_seq.sv
// Scan sequencer: walks the used positions through one shared key comparator.
// Depends on eir_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "external_id_remapper_macros.svh"

module eir_scan_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [eir_pkg::EXT_W-1:0] ext_key_i,
  output eir_pkg::mem_req_t       mem_req_o,
  input  eir_pkg::key_t           rd_data_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output eir_pkg::res_t           res_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  localparam eir_pkg::count_t FullCount = eir_pkg::COUNT_W'(eir_pkg::ENTRIES);

  state_e          state_q, state_d;
  eir_pkg::key_t   key_q, key_d;
  eir_pkg::count_t used_q, used_d;
  eir_pkg::count_t scan_idx_q, scan_idx_d;
  logic            pend_q, pend_d;
  eir_pkg::index_t pend_idx_q, pend_idx_d;

  logic hit;
  logic more;

  // Shared comparator and bound check.
  assign hit  = pend_q && (rd_data_i == key_q);
  assign more = (scan_idx_q < used_q);

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: while scanning, one read issued and one key compared per cycle.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    used_d      = used_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d      = eir_pkg::KEY_BITS'(ext_key_i);
          scan_idx_d = '0;
          pend_d     = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Stored key found at the position just read.
          if (res_ready_i) begin
            res_valid_o     = 1'b1;
            res_o.dense_idx = eir_pkg::ID_W'(pend_idx_q);
            state_d         = ST_IDLE;
          end
        end else if (more) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = scan_idx_q[eir_pkg::INDEX_W-1:0];
          pend_d            = 1'b1;
          pend_idx_d        = scan_idx_q[eir_pkg::INDEX_W-1:0];
          scan_idx_d        = scan_idx_q + eir_pkg::count_t'(1);
        end else if (res_ready_i) begin
          // Miss: append the key unless the table is full.
          res_valid_o = 1'b1;
          if (used_q == FullCount) begin
            res_o.table_full = 1'b1;
          end else begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = used_q[eir_pkg::INDEX_W-1:0];
            mem_req_o.wr_data = key_q;
            res_o.dense_idx   = eir_pkg::ID_W'(used_q[eir_pkg::INDEX_W-1:0]);
            res_o.is_new      = 1'b1;
            used_d            = used_q + eir_pkg::count_t'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      scan_idx_q <= scan_idx_d;
      pend_q     <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pend_idx_q <= pend_idx_d;
  end

  `EIR_ASSERT_NOW(a_used_bound, 1'b1, used_q <= FullCount)
  `EIR_ASSERT_NOW(a_write_room, mem_req_o.wr_en, used_q < FullCount)
  `EIR_ASSERT_NOW(a_read_in_use, mem_req_o.rd_en, scan_idx_q < used_q)
  `EIR_ASSERT_NEXT(a_write_counts, mem_req_o.wr_en, used_q == $past(used_q) + eir_pkg::count_t'(1))
  `EIR_ASSERT_NOW(a_flags_apart, res_valid_o, !(res_o.is_new && res_o.table_full))

endmodule

>>> verif/tb.sv
// Self-checking testbench for the external identifier remapper.
// Needs eir_pkg, the eir_in_if/eir_out_if channel interfaces and external_id_remapper.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_WAIT    = 19;
  localparam int unsigned RAND_LOOKUPS = 564;
  localparam longint unsigned CYCLE_LIMIT = 5_000_000;

  // Scoreboard: keeps its own copy of the dense id table and predicts each answer.
  class id_table_scoreboard;
    eir_pkg::key_t assigned_keys[$];
    eir_pkg::res_t pending_answers[$];
    int unsigned   faults;

    // Work out the answer for an accepted lookup and update the table copy.
    function void note_lookup(logic [eir_pkg::EXT_W-1:0] ext);
      eir_pkg::key_t key;
      eir_pkg::res_t answer;
      int            hit_at;
      key    = eir_pkg::key_t'(ext);
      answer = '0;
      hit_at = -1;
      // The block returns the lowest matching position.
      for (int i = 0; i < assigned_keys.size() && hit_at < 0; i++) begin
        if (assigned_keys[i] == key) hit_at = i;
      end
      if (hit_at >= 0) begin
        answer.dense_idx = eir_pkg::ID_W'(hit_at);
      end else if (assigned_keys.size() >= eir_pkg::ENTRIES) begin
        // Miss on a full table: nothing stored, index reads as zero.
        answer.table_full = 1'b1;
      end else begin
        answer.dense_idx = eir_pkg::ID_W'(assigned_keys.size());
        answer.is_new    = 1'b1;
        assigned_keys.insert(assigned_keys.size(), key);
      end
      pending_answers.insert(pending_answers.size(), answer);
    endfunction

    // Compare one accepted result with the oldest predicted answer.
    function void check_answer(logic [eir_pkg::ID_W-1:0] id, logic is_new, logic full);
      eir_pkg::res_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: dense_idx %0d is_new %0b table_full %0b",
               id, is_new, full);
        faults++;
        return;
      end
      want = pending_answers.pop_front();
      if (id !== want.dense_idx) begin
        $error("dense_idx: expected %0d, got %0d", want.dense_idx, id);
        faults++;
      end
      if (is_new !== want.is_new) begin
        $error("is_new: expected %0b, got %0b", want.is_new, is_new);
        faults++;
      end
      if (full !== want.table_full) begin
        $error("table_full: expected %0b, got %0b", want.table_full, full);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  longint unsigned cycle_count;
  int          lookup_quiet;
  int          answer_quiet;

  id_table_scoreboard board;

  eir_in_if  lookup_ch ();
  eir_out_if answer_ch ();

  external_id_remapper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (lookup_ch),
    .out_o  (answer_ch)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Wait before the next item: mostly random, with occasional runs of back-to-back items.
  function automatic int unsigned pick_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Any identifier that already has an internal id.
  function automatic logic [eir_pkg::EXT_W-1:0] pick_known();
    return eir_pkg::EXT_W'(board.assigned_keys[$urandom_range(0,
                                                board.assigned_keys.size() - 1)]);
  endfunction

  // Offer one identifier and hold it until the block takes it.
  task automatic send_id(input logic [eir_pkg::EXT_W-1:0] ext);
    int unsigned gap;
    gap = pick_wait(lookup_quiet);
    if (gap > 0) begin
      lookup_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    lookup_ch.valid   <= 1'b1;
    lookup_ch.ext_key <= ext;
    do @(posedge clk_i); while (!lookup_ch.ready);
    board.note_lookup(ext);
  endtask

  // Result side: stall at random, then take one item and check it.
  initial begin
    int unsigned stall;
    answer_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_wait(answer_quiet);
      if (stall > 0) begin
        answer_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      answer_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!answer_ch.valid);
      board.check_answer(answer_ch.dense_idx, answer_ch.is_new, answer_ch.table_full);
    end
  end

  // Stimulus: corner identifiers, then a random mix of fresh, known and near-miss identifiers.
  initial begin
    int unsigned roll;
    board        = new();
    lookup_quiet = 0;
    answer_quiet = 0;
    rst_ni            <= 1'b0;
    lookup_ch.valid   <= 1'b0;
    lookup_ch.ext_key <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes, bit patterns and repeats that must hit.
    send_id(32'h0000_0000);
    send_id(32'h0000_0000);
    send_id(32'hFFFF_FFFF);
    send_id(32'hAAAA_AAAA);
    send_id(32'h5555_5555);
    send_id(32'h8000_0000);
    send_id(32'h0000_0001);
    send_id(32'h7FFF_FFFF);
    send_id(32'hFFFF_FFFE);
    send_id(32'hFFFF_FFFF);
    send_id(32'h0000_0000);
    send_id(32'h5555_5555);
    send_id(32'h0000_0001);
    send_id(32'h8000_0001);
    send_id(32'hAAAA_AAAA);
    send_id(32'h7FFF_FFFF);

    // Random mix of fresh identifiers, repeats and near misses of known ones.
    repeat (RAND_LOOKUPS) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_id($urandom());
      end else if (roll < 90) begin
        send_id(pick_known());
      end else begin
        send_id(pick_known() ^ (32'h1 << $urandom_range(0, eir_pkg::EXT_W - 1)));
      end
    end
    lookup_ch.valid <= 1'b0;

    // Drain the outstanding answers, then watch for stray results.
    while (board.pending_answers.size() != 0) @(posedge clk_i);
    repeat (eir_pkg::ENTRIES + 2) @(posedge clk_i);

    if (board.faults == 0 && board.pending_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
